/* rtl/core/char_stream_tokenizer_defines.svh */
// Assertion macros shared by the tokenizer RTL files.
`ifndef CHAR_STREAM_TOKENIZER_DEFINES_SVH
`define CHAR_STREAM_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define CST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tokenizer assertion failed");

// Condition that must never be seen at a clock edge outside reset.
`define CST_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tokenizer forbidden condition seen");

`else

`define CST_ASSERT(lbl, clk, rst_n, prop)
`define CST_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* rtl/core/cst_pkg.sv */
// Shared types and constants of the character stream tokenizer.
`default_nettype none

package cst_pkg;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SYMBOL_CHARS = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXTRA_SYMBOL = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COMMENT_CHAR = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VARIABLE_CHAR = 8'd3;

    localparam logic [7:0] COMMENT_CHAR_RESET  = 8'd37;
    localparam logic [7:0] VARIABLE_CHAR_RESET = 8'd95;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NONE  = 8'd0;

    typedef enum logic [1:0] {
        KIND_WORD_CHAR = 2'd0,
        KIND_WORD_END  = 2'd1,
        KIND_SYMBOL    = 2'd2,
        KIND_ERROR     = 2'd3
    } kind_t;

    // One queue entry: one or two results of a single item. A lone result
    // always travels in the second slot.
    typedef struct packed {
        logic       two;
        kind_t      kind_a;
        logic [7:0] char_a;
        kind_t      kind_b;
        logic [7:0] char_b;
    } tok_pair_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

/* rtl/core/cst_queue.sv */
// Short queue between the classifying front and the result back end.
`default_nettype none
`include "char_stream_tokenizer_defines.svh"

module cst_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [WIDTH-1:0]     push_data,
    input  wire logic                 pop,
    output logic [WIDTH-1:0]          head_data,
    output cst_pkg::queue_status_t    status
);

    localparam int DEPTH = cst_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign status.full  = (count_reg == (AW + 1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_data    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `CST_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && status.full && !pop)
    `CST_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && status.empty)
    `CST_ASSERT(a_count_bound, clk, rst_n, count_reg <= (AW + 1)'(DEPTH))

endmodule

`default_nettype wire

/* rtl/core/cst_front.sv */
// Front end: configuration registers, item acceptance, scan state and classification.
`default_nettype none

module cst_front #(
    parameter int LINE_WIDTH   = 16,
    parameter int COLUMN_WIDTH = 24
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [cst_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [cst_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_op,
    input  wire logic [7:0]                           in_char,
    input  wire logic                                 in_ready,
    output logic                                      push,
    output cst_pkg::tok_pair_t                        push_pair,
    output logic [LINE_WIDTH-1:0]                     push_line,
    output logic [COLUMN_WIDTH-1:0]                   push_column
);

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_SPACES  = 2'd1,
        MODE_COMMENT = 2'd3
    } mode_t;

    localparam logic [LINE_WIDTH-1:0]   LINE_ONE   = LINE_WIDTH'(1);
    localparam logic [COLUMN_WIDTH-1:0] COLUMN_ONE = COLUMN_WIDTH'(1);

    logic [63:0] symbol_chars_reg;
    logic [7:0]  extra_symbol_reg;
    logic [7:0]  comment_char_reg;
    logic [7:0]  variable_char_reg;

    mode_t                   mode_reg, mode_next;
    logic                    word_open_reg, word_open_next;
    logic [LINE_WIDTH-1:0]   line_reg, line_next;
    logic [COLUMN_WIDTH-1:0] column_reg, column_next;
    logic                    halted_reg, halted_next;

    logic accept;
    logic is_letter;
    logic is_symbol;
    logic is_word;
    logic is_valid;
    logic gen_en;
    logic gen_run;

    assign accept    = in_valid && in_ready;
    assign is_letter = ((in_char >= 8'd65) && (in_char <= 8'd90)) ||
                       ((in_char >= 8'd97) && (in_char <= 8'd122));
    assign is_word   = is_letter || (in_char == variable_char_reg);

    always_comb
    begin
        is_symbol = (extra_symbol_reg != 8'd0) && (extra_symbol_reg == in_char);
        for (int i = 0; i < 8; i++)
        begin
            if ((symbol_chars_reg[8*i +: 8] != 8'd0) && (symbol_chars_reg[8*i +: 8] == in_char))
            begin
                is_symbol = 1'b1;
            end
        end
    end

    assign is_valid = (mode_reg == MODE_COMMENT) || is_letter || (in_char == cst_pkg::CH_NL) ||
                      (in_char == cst_pkg::CH_TAB) || (in_char == cst_pkg::CH_SPACE) ||
                      is_symbol || (in_char == comment_char_reg) ||
                      (in_char == variable_char_reg);

    always_comb
    begin
        mode_next      = mode_reg;
        word_open_next = word_open_reg;
        line_next      = line_reg;
        column_next    = column_reg;
        halted_next    = halted_reg;
        push           = 1'b0;
        push_pair      = '{two: 1'b0, kind_a: cst_pkg::KIND_WORD_CHAR, char_a: cst_pkg::CH_NONE,
                           kind_b: cst_pkg::KIND_WORD_CHAR, char_b: cst_pkg::CH_NONE};
        push_line      = line_reg;
        push_column    = column_reg;
        gen_en         = 1'b0;
        gen_run        = 1'b0;

        if (accept)
        begin
            if (in_op)
            begin
                mode_next      = MODE_NORMAL;
                word_open_next = 1'b0;
                line_next      = LINE_ONE;
                column_next    = COLUMN_ONE;
                halted_next    = 1'b0;
            end
            else if (!halted_reg)
            begin
                if (!is_valid)
                begin
                    // The column does not advance on the offending byte.
                    push             = 1'b1;
                    push_pair.kind_b = cst_pkg::KIND_ERROR;
                    push_pair.char_b = in_char;
                    halted_next      = 1'b1;
                end
                else
                begin
                    case (mode_reg)
                        MODE_NORMAL:
                        begin
                            if (in_char == cst_pkg::CH_SPACE)
                            begin
                                if (word_open_reg)
                                begin
                                    mode_next = MODE_SPACES;
                                end
                            end
                            else if (in_char == comment_char_reg)
                            begin
                                mode_next = MODE_COMMENT;
                            end
                            else
                            begin
                                gen_en = 1'b1;
                            end
                        end
                        MODE_COMMENT:
                        begin
                            if (in_char == cst_pkg::CH_NL)
                            begin
                                mode_next = MODE_NORMAL;
                                gen_en    = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Space run inside a word; the unused mode code acts the same.
                            if (in_char != cst_pkg::CH_SPACE)
                            begin
                                gen_en    = 1'b1;
                                gen_run   = 1'b1;
                                mode_next = MODE_NORMAL;
                            end
                        end
                    endcase

                    if (gen_en)
                    begin
                        if (is_word)
                        begin
                            push             = 1'b1;
                            push_pair.two    = gen_run;
                            push_pair.kind_a = cst_pkg::KIND_WORD_CHAR;
                            push_pair.char_a = cst_pkg::CH_SPACE;
                            push_pair.kind_b = cst_pkg::KIND_WORD_CHAR;
                            push_pair.char_b = in_char;
                            word_open_next   = 1'b1;
                        end
                        else if (in_char == cst_pkg::CH_NL)
                        begin
                            if (line_reg != '1)
                            begin
                                line_next = line_reg + LINE_ONE;
                            end
                        end
                        else if (in_char != cst_pkg::CH_TAB)
                        begin
                            push             = 1'b1;
                            push_pair.two    = word_open_reg;
                            push_pair.kind_a = cst_pkg::KIND_WORD_END;
                            push_pair.char_a = cst_pkg::CH_NONE;
                            push_pair.kind_b = cst_pkg::KIND_SYMBOL;
                            push_pair.char_b = in_char;
                            word_open_next   = 1'b0;
                        end
                    end

                    if (column_reg != '1)
                    begin
                        column_next = column_reg + COLUMN_ONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_chars_reg  <= '0;
            extra_symbol_reg  <= '0;
            comment_char_reg  <= cst_pkg::COMMENT_CHAR_RESET;
            variable_char_reg <= cst_pkg::VARIABLE_CHAR_RESET;
            mode_reg          <= MODE_NORMAL;
            word_open_reg     <= 1'b0;
            line_reg          <= LINE_ONE;
            column_reg        <= COLUMN_ONE;
            halted_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cst_pkg::CFG_SYMBOL_CHARS:  symbol_chars_reg  <= cfg_data;
                    cst_pkg::CFG_EXTRA_SYMBOL:  extra_symbol_reg  <= cfg_data[7:0];
                    cst_pkg::CFG_COMMENT_CHAR:  comment_char_reg  <= cfg_data[7:0];
                    cst_pkg::CFG_VARIABLE_CHAR: variable_char_reg <= cfg_data[7:0];
                    default:                    symbol_chars_reg  <= symbol_chars_reg;
                endcase
            end
            mode_reg      <= mode_next;
            word_open_reg <= word_open_next;
            line_reg      <= line_next;
            column_reg    <= column_next;
            halted_reg    <= halted_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cst_back.sv */
// Back end: drains queue entries into the registered result stream.
`default_nettype none
`include "char_stream_tokenizer_defines.svh"

module cst_back #(
    parameter int LINE_WIDTH   = 16,
    parameter int COLUMN_WIDTH = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cst_pkg::queue_status_t      status,
    input  wire cst_pkg::tok_pair_t          head_pair,
    input  wire logic [LINE_WIDTH-1:0]       head_line,
    input  wire logic [COLUMN_WIDTH-1:0]     head_column,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output cst_pkg::kind_t                   out_kind,
    output logic [7:0]                       out_char,
    output logic [LINE_WIDTH-1:0]            out_line,
    output logic [COLUMN_WIDTH-1:0]          out_column,
    output logic                             out_last
);

    logic                    valid_reg;
    logic                    phase_reg;
    cst_pkg::kind_t          kind_reg;
    logic [7:0]              char_reg;
    logic [LINE_WIDTH-1:0]   line_reg;
    logic [COLUMN_WIDTH-1:0] column_reg;
    logic                    last_reg;
    logic                    load;
    logic                    take_first;

    assign load       = !status.empty && (!valid_reg || out_ready);
    assign take_first = head_pair.two && !phase_reg;
    assign pop        = load && !take_first;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= take_first;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= take_first ? head_pair.kind_a : head_pair.kind_b;
            char_reg   <= take_first ? head_pair.char_a : head_pair.char_b;
            line_reg   <= head_line;
            column_reg <= head_column;
            last_reg   <= !take_first;
        end
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_char   = char_reg;
    assign out_line   = line_reg;
    assign out_column = column_reg;
    assign out_last   = last_reg;

    `CST_ASSERT(a_phase_shows_first, clk, rst_n, phase_reg |-> (valid_reg && !last_reg))
    `CST_ASSERT(a_phase_holds_entry, clk, rst_n, phase_reg |-> !status.empty)

endmodule

`default_nettype wire

/* rtl/core/char_stream_tokenizer.sv */
// Top level of the character stream tokenizer: front end, queue and back end.
// The first result of an item passes through the queue and then the output register.
// One item per cycle while the queue has room; m_tlast marks the last result of an item.
// The four-entry queue lets items keep entering while results wait on m_tready.
// Reset (rst_n, asynchronous, active low) clears the queue and the scan state and
// loads the register reset values; there is no clearing pass.
`default_nettype none

module char_stream_tokenizer #(
    parameter int LINE_WIDTH   = 16,
    parameter int COLUMN_WIDTH = 24
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // Configuration write port.
    input  wire logic                                 cfg_we,
    input  wire logic [cst_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [cst_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,

    // Input items.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [7:0]                           s_tdata,  // [7:0] character
    input  wire logic [0:0]                           s_tuser,  // [0] operation

    // Result items.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // From bit 0 up: token_char, line, column, zero padding to whole bytes.
    output logic [((8 + LINE_WIDTH + COLUMN_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [1:0]                                m_tuser,  // [1:0] kind
    output logic                                      m_tlast
);

    localparam int DATA_W    = 8 + LINE_WIDTH + COLUMN_WIDTH;
    localparam int TDATA_W   = ((DATA_W + 7) / 8) * 8;
    localparam int PAIR_W    = $bits(cst_pkg::tok_pair_t);
    localparam int ENTRY_W   = PAIR_W + LINE_WIDTH + COLUMN_WIDTH;

    // Front-end outputs toward the queue.
    logic                    push;
    cst_pkg::tok_pair_t      push_pair;
    logic [LINE_WIDTH-1:0]   push_line;
    logic [COLUMN_WIDTH-1:0] push_column;

    // Queue head as seen by the back end.
    logic [ENTRY_W-1:0]      head_data;
    cst_pkg::tok_pair_t      head_pair;
    logic [LINE_WIDTH-1:0]   head_line;
    logic [COLUMN_WIDTH-1:0] head_column;
    cst_pkg::queue_status_t  status;
    logic                    pop;

    cst_pkg::kind_t          out_kind;
    logic [7:0]              out_char;
    logic [LINE_WIDTH-1:0]   out_line;
    logic [COLUMN_WIDTH-1:0] out_column;

    // An item is taken whenever the queue has room, including items that
    // cause no result, so the front never waits on the output side directly.
    assign s_tready = !status.full;

    cst_front #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_op       (s_tuser[0]),
        .in_char     (s_tdata),
        .in_ready    (s_tready),
        .push        (push),
        .push_pair   (push_pair),
        .push_line   (push_line),
        .push_column (push_column)
    );

    cst_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_pair, push_line, push_column}),
        .pop       (pop),
        .head_data (head_data),
        .status    (status)
    );

    assign head_pair   = cst_pkg::tok_pair_t'(head_data[ENTRY_W-1 -: PAIR_W]);
    assign head_line   = head_data[COLUMN_WIDTH +: LINE_WIDTH];
    assign head_column = head_data[COLUMN_WIDTH-1:0];

    cst_back #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .status      (status),
        .head_pair   (head_pair),
        .head_line   (head_line),
        .head_column (head_column),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_char    (out_char),
        .out_line    (out_line),
        .out_column  (out_column),
        .out_last    (m_tlast)
    );

    // Pack the result fields from the lowest bit up and zero-fill to bytes.
    assign m_tdata = TDATA_W'({out_column, out_line, out_char});
    assign m_tuser = out_kind;

endmodule

`default_nettype wire
